/* hw/rtl/frd_pkg.sv */
// Shared types and constants for the flood rate detector.
// Used by frd_cam and flood_rate_detector; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package frd_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_WIDTH   = 32;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // Counter store: one row per (rule, slot) pair
  localparam int CNT_AW        = SLOT_W + 1;
  localparam int CNT_DEPTH     = 2 ** CNT_AW;

  // Protocol numbers
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  // Rule codes
  localparam logic RULE_SYN  = 1'b0;
  localparam logic RULE_ICMP = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYN_THR  = 2'd0;
  localparam logic [1:0] CFG_ICMP_THR = 2'd1;
  localparam logic [1:0] CFG_SYN_EN   = 2'd2;
  localparam logic [1:0] CFG_ICMP_EN  = 2'd3;

  typedef struct packed {
    logic [7:0]  protocol;
    logic        syn_flag;
    logic        ack_flag;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic        rule_code;
    logic [31:0] alert_src_ip;
    logic [31:0] alert_dst_ip;
    logic [15:0] alert_src_port;
    logic [15:0] alert_dst_port;
    logic [31:0] packet_count;
  } out_item_t;

  // Source table lookup result
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } cam_res_t;

endpackage

`default_nettype wire

/* hw/rtl/frd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module frd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/frd_cam.sv */
// Source address table: parallel match, lowest-free allocation, valid bits.
// Depends on frd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frd_cam (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             lookup_en,
  input  wire logic [31:0]      key,
  output frd_pkg::cam_res_t     res
);

  logic [31:0]                         addr_r [frd_pkg::TABLE_ENTRIES];
  logic [frd_pkg::TABLE_ENTRIES-1:0]   vld_r;

  logic                        hit;
  logic [frd_pkg::SLOT_W-1:0]  hit_slot;
  logic                        free_any;
  logic [frd_pkg::SLOT_W-1:0]  free_slot;
  logic                        alloc;

  // Match all valid entries; at most one can hit
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < frd_pkg::TABLE_ENTRIES; i++) begin
      if (vld_r[i] && (addr_r[i] == key)) begin
        hit      = 1'b1;
        hit_slot = hit_slot | frd_pkg::SLOT_W'(i);
      end
    end
  end

  // Find the lowest free entry
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = frd_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_any  = 1'b1;
        free_slot = frd_pkg::SLOT_W'(i);
      end
    end
  end

  assign alloc     = lookup_en && !hit && free_any;
  assign res.found = hit || free_any;
  assign res.slot  = hit ? hit_slot : free_slot;

  // Mark newly allocated entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (alloc) begin
      vld_r[free_slot] <= 1'b1;
    end
  end

  // Store the source address of a new entry
  always_ff @(posedge clk) begin
    if (alloc) begin
      addr_r[free_slot] <= key;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/flood_rate_detector.sv */
// An alert passes through the input, lookup and output registers after its header transfer.
// Throughput: one header per cycle; a stalled alert freezes the whole pipeline.
// The per-source counter store is a RAM with registered read; a one-deep bypass
// covers back-to-back updates of the same counter.
// Reset: thresholds 100, both rules enabled, source table empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module flood_rate_detector (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Header channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire frd_pkg::in_item_t   in_data,
  // Alert channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output frd_pkg::out_item_t       out_data,
  // Configuration
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata
);

  // Configuration registers
  logic [31:0] syn_thr_r;
  logic [31:0] icmp_thr_r;
  logic        syn_en_r;
  logic        icmp_en_r;

  // Pipeline control
  logic adv;

  // Input stage
  logic              a_vld_r;
  frd_pkg::in_item_t a_data_r;
  logic              cnt_syn;
  logic              cnt_icmp;
  logic              counted;
  logic              a_kind;
  logic              lookup_en;
  frd_pkg::cam_res_t cam_res;
  logic [frd_pkg::CNT_AW-1:0] a_addr;

  // Lookup stage
  logic                        b_vld_r;
  logic                        b_kind_r;
  logic [frd_pkg::SLOT_W-1:0]  b_slot_r;
  logic                        b_live_r;
  frd_pkg::in_item_t           b_data_r;
  logic [frd_pkg::CNT_AW-1:0]  b_addr;

  // Counter store and bypass
  logic [frd_pkg::CNT_DEPTH-1:0]   live_r;
  logic [frd_pkg::COUNT_WIDTH-1:0] ram_q;
  logic                            ram_we;
  logic                            fwd_vld_r;
  logic [frd_pkg::CNT_AW-1:0]      fwd_addr_r;
  logic [frd_pkg::COUNT_WIDTH-1:0] fwd_val_r;
  logic [frd_pkg::COUNT_WIDTH-1:0] cnt_old;
  logic [frd_pkg::COUNT_WIDTH-1:0] cnt_new;
  logic [31:0]                     cnt_ext;
  logic [31:0]                     thr;
  logic                            fire;

  // Output stage
  logic               out_valid_r;
  frd_pkg::out_item_t out_data_r;
  frd_pkg::out_item_t out_nxt;

  // Whole pipeline moves unless a finished alert is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syn_thr_r  <= 32'd100;
      icmp_thr_r <= 32'd100;
      syn_en_r   <= 1'b1;
      icmp_en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        frd_pkg::CFG_SYN_THR:  syn_thr_r  <= cfg_wdata;
        frd_pkg::CFG_ICMP_THR: icmp_thr_r <= cfg_wdata;
        frd_pkg::CFG_SYN_EN:   syn_en_r   <= cfg_wdata[0];
        frd_pkg::CFG_ICMP_EN:  icmp_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      a_data_r <= in_data;
    end
  end

  // Classify the packet against enabled rules
  assign cnt_syn   = syn_en_r && (a_data_r.protocol == frd_pkg::PROTO_TCP) &&
                     a_data_r.syn_flag && !a_data_r.ack_flag;
  assign cnt_icmp  = icmp_en_r && (a_data_r.protocol == frd_pkg::PROTO_ICMP);
  assign counted   = cnt_syn || cnt_icmp;
  assign a_kind    = cnt_syn ? frd_pkg::RULE_SYN : frd_pkg::RULE_ICMP;
  assign lookup_en = adv && a_vld_r && counted;
  assign a_addr    = {a_kind, cam_res.slot};

  frd_cam u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_en (lookup_en),
    .key       (a_data_r.src_ip),
    .res       (cam_res)
  );

  // Lookup stage register; drop packets not counted or with a full table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r && counted && cam_res.found;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_kind_r <= a_kind;
      b_slot_r <= cam_res.slot;
      b_live_r <= live_r[a_addr];
      b_data_r <= a_data_r;
    end
  end

  assign b_addr = {b_kind_r, b_slot_r};
  assign ram_we = adv && b_vld_r;

  frd_ram #(
    .WIDTH (frd_pkg::COUNT_WIDTH),
    .DEPTH (frd_pkg::CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_addr),
    .wdata (cnt_new),
    .re    (adv),
    .raddr (a_addr),
    .rdata (ram_q)
  );

  // Counters never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (ram_we) begin
      live_r[b_addr] <= 1'b1;
    end
  end

  // Bypass the write that landed at the same edge as this read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      fwd_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr_r <= b_addr;
      fwd_val_r  <= cnt_new;
    end
  end

  // Saturating increment and threshold compare
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == b_addr)) begin
      cnt_old = fwd_val_r;
    end else if (b_live_r) begin
      cnt_old = ram_q;
    end else begin
      cnt_old = '0;
    end
    cnt_new = (&cnt_old) ? cnt_old : cnt_old + frd_pkg::COUNT_WIDTH'(1);
    cnt_ext = 32'(cnt_new);
    thr     = (b_kind_r == frd_pkg::RULE_SYN) ? syn_thr_r : icmp_thr_r;
    fire    = (cnt_ext >= thr);
  end

  // Build the alert
  always_comb begin
    out_nxt.rule_code      = b_kind_r;
    out_nxt.alert_src_ip   = b_data_r.src_ip;
    out_nxt.alert_dst_ip   = b_data_r.dst_ip;
    out_nxt.alert_src_port = (b_kind_r == frd_pkg::RULE_SYN) ? b_data_r.src_port : 16'd0;
    out_nxt.alert_dst_port = (b_kind_r == frd_pkg::RULE_SYN) ? b_data_r.dst_port : 16'd0;
    out_nxt.packet_count   = cnt_ext;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_vld_r && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_vld_r && fire) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_at_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.packet_count >=
                   ((out_data.rule_code == frd_pkg::RULE_SYN) ? syn_thr_r : icmp_thr_r)))
    else $error("alert below its threshold");

  a_icmp_ports_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.rule_code == frd_pkg::RULE_ICMP)) |->
      ((out_data.alert_src_port == 16'd0) && (out_data.alert_dst_port == 16'd0)))
    else $error("ICMP alert with nonzero ports");

  a_rule_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.rule_code == frd_pkg::RULE_SYN) ? syn_en_r : icmp_en_r))
    else $error("alert from a disabled rule");

  a_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && b_vld_r) |-> (cnt_new != '0))
    else $error("counter update produced zero");

endmodule

`default_nettype wire
